[hdl/rotenc_pkg.sv]
// ----------------------------------------------------------------------------
// rotenc_pkg
// shared types and constants of the rotary encoder detent decoder
// ----------------------------------------------------------------------------
package rotenc_pkg;

  // event codes carried on the input channel, code 3 has no meaning
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ENC    = 2'd1,
    CMD_SWITCH = 2'd2
  } cmd_e;

  // rotation direction
  typedef enum logic [1:0] {
    DIR_STOPPED = 2'd0,
    DIR_CW      = 2'd1,
    DIR_CCW     = 2'd2
  } dir_e;

  localparam int unsigned DebounceW = 10;
  localparam int unsigned PosW      = 16;

  localparam logic [DebounceW-1:0] DebounceReset = 10'd50;
  localparam logic [1:0]           PulsesPerTurn = 2'd2;

  typedef logic [DebounceW-1:0]     debounce_t;
  typedef logic signed [PosW-1:0]   pos_t;

endpackage

[hdl/rotenc_item_if.sv]
// ----------------------------------------------------------------------------
// rotenc_item_if
// input event channel: valid/ready handshake with encoder and switch levels
// ----------------------------------------------------------------------------
interface rotenc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       pin_a;
  logic       pin_b;
  logic       pin_switch;

  modport source (output valid, command, pin_a, pin_b, pin_switch, input ready);
  modport sink   (input valid, command, pin_a, pin_b, pin_switch, output ready);
endinterface

[hdl/rotenc_result_if.sv]
// ----------------------------------------------------------------------------
// rotenc_result_if
// result channel: valid/ready handshake with turn, press and position
// ----------------------------------------------------------------------------
interface rotenc_result_if;
  logic              valid;
  logic              ready;
  logic              turn_valid;
  logic [1:0]        turn_direction;
  logic              press_valid;
  logic signed [15:0] position;

  modport source (output valid, turn_valid, turn_direction, press_valid, position,
                  input ready);
  modport sink   (input valid, turn_valid, turn_direction, press_valid, position,
                  output ready);
endinterface

[hdl/rotary_encoder_detent_decoder.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_detent_decoder
// quadrature encoder detent decoder with a debounced push switch
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  item_i    in   valid/ready   command, pin_a, pin_b, pin_switch
//  result_o  out  valid/ready   turn_valid, turn_direction, press_valid, position
//  cfg       in   we only       debounce_ticks (10 bit)
//
//  one item per cycle sustained while the result is taken; an item passes through
//  the input register, then the result register
//  the decoder state is updated in the same cycle the result register loads
//  reset returns the valid flags and decoder state to their reset values, debounce_ticks to 50
//  a stalled result holds the input stage; the input stage still takes a new
//  item as long as the result register is empty or being taken
// ----------------------------------------------------------------------------
module rotary_encoder_detent_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  rotenc_pkg::debounce_t cfg_wdata_i,
  rotenc_item_if.sink           item_i,
  rotenc_result_if.source       result_o
);
  import rotenc_pkg::*;

  // configuration register
  debounce_t debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  // input register stage
  logic       s1_valid_q;
  logic [1:0] s1_cmd_q;
  logic       s1_a_q, s1_b_q, s1_sw_q;
  logic       s1_adv;
  logic       in_xfer;

  // result register stage
  logic       out_valid_q;
  logic       out_turn_q;
  dir_e       out_dir_q;
  logic       out_press_q;
  pos_t       out_pos_q;

  // decoder state
  logic       sync_q,       sync_d;
  dir_e       dir_now_q,    dir_now_d;
  dir_e       dir_last_q,   dir_last_d;
  logic [1:0] pulse_q,      pulse_d;
  pos_t       pos_q,        pos_d;
  logic       sw_prev_q,    sw_prev_d;
  debounce_t  ignore_q,     ignore_d;
  logic       turn_d, press_d;

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv       = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q <= item_i.command;
      s1_a_q   <= item_i.pin_a;
      s1_b_q   <= item_i.pin_b;
      s1_sw_q  <= item_i.pin_switch;
    end
  end

  // event decode against current state
  always_comb begin
    logic       nxt;
    dir_e       last_n;
    logic [1:0] pulse_n;
    nxt        = ~sync_q;
    last_n     = dir_last_q;
    pulse_n    = pulse_q;
    sync_d     = sync_q;
    dir_now_d  = dir_now_q;
    dir_last_d = dir_last_q;
    pulse_d    = pulse_q;
    pos_d      = pos_q;
    sw_prev_d  = sw_prev_q;
    ignore_d   = ignore_q;
    turn_d     = 1'b0;
    press_d    = 1'b0;

    case (s1_cmd_q)
      CMD_TICK: begin
        // window counts down to zero and stays there
        if (ignore_q != '0) begin
          ignore_d = ignore_q - debounce_t'(1);
        end
      end
      CMD_ENC: begin
        if (s1_a_q == nxt && s1_b_q == sync_q) begin
          dir_now_d = DIR_CW;
        end else if (s1_b_q == nxt && s1_a_q == sync_q) begin
          dir_now_d = DIR_CCW;
        end else if (s1_a_q == sync_q && s1_b_q == sync_q) begin
          dir_now_d = DIR_STOPPED;
        end else begin
          // both pins at the next level: one pulse done
          if (dir_now_q == DIR_CW) begin
            pos_d  = pos_q + pos_t'(1);
            last_n = DIR_CW;
          end else if (dir_now_q == DIR_CCW) begin
            pos_d  = pos_q - pos_t'(1);
            last_n = DIR_CCW;
          end
          // a change of direction restarts the pulse pair
          if (last_n == dir_now_q) begin
            pulse_n = pulse_q + 2'd1;
          end else begin
            pulse_n = 2'd1;
          end
          if (pulse_n == PulsesPerTurn) begin
            pulse_n = 2'd0;
            turn_d  = 1'b1;
          end
          dir_last_d = last_n;
          pulse_d    = pulse_n;
          sync_d     = nxt;
        end
      end
      CMD_SWITCH: begin
        // falling edge counts only once the window has run out
        press_d = !s1_sw_q && sw_prev_q && (ignore_q == '0);
        if (s1_sw_q != sw_prev_q) begin
          ignore_d  = debounce_q;
          sw_prev_d = s1_sw_q;
        end
      end
      default: begin
        // unused code leaves the state alone
      end
    endcase
  end

  // state commits together with the result register load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q     <= 1'b0;
      dir_now_q  <= DIR_STOPPED;
      dir_last_q <= DIR_STOPPED;
      pulse_q    <= 2'd0;
      pos_q      <= '0;
      sw_prev_q  <= 1'b1;
      ignore_q   <= '0;
    end else if (s1_adv) begin
      sync_q     <= sync_d;
      dir_now_q  <= dir_now_d;
      dir_last_q <= dir_last_d;
      pulse_q    <= pulse_d;
      pos_q      <= pos_d;
      sw_prev_q  <= sw_prev_d;
      ignore_q   <= ignore_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_turn_q  <= turn_d;
      out_dir_q   <= dir_last_d;
      out_press_q <= press_d;
      out_pos_q   <= pos_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.turn_valid     = out_turn_q;
  assign result_o.turn_direction = out_dir_q;
  assign result_o.press_valid    = out_press_q;
  assign result_o.position       = out_pos_q;

  // checks
  a_no_turn_and_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_turn_q && out_press_q))
    else $error("turn and press on the same result");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> item_i.ready)
    else $error("input stalled with empty result register");

  a_turn_clears_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && turn_d) |=> (pulse_q == 2'd0))
    else $error("pulse count not cleared after turn");

  a_position_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (pos_q == $past(pos_q) || pos_q == $past(pos_q) + pos_t'(1) ||
              pos_q == $past(pos_q) - pos_t'(1)))
    else $error("position moved by more than one step");

  a_sync_flip_on_enc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sync_q != $past(sync_q)) |-> $past(s1_adv && s1_cmd_q == CMD_ENC))
    else $error("sync level flipped without an encoder event");

endmodule
